FILE: hdl/q4gq_pkg.sv
// Shared constants and types for the 4-bit group quantizer.
package q4gq_pkg;

  localparam int GROUP_SIZE  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int LANES       = 16;
  localparam int CODE_BITS   = 4;
  localparam int CODE_MAX    = 15;
  localparam int WORD_COUNT  = GROUP_SIZE / LANES;
  localparam int WORD_BITS   = LANES * CODE_BITS;
  localparam int ADDR_W      = $clog2(GROUP_SIZE);
  localparam int LANE_W      = $clog2(LANES);
  localparam int WIDX_W      = 4;
  localparam int SCALE_W     = 21;
  localparam int NUM_W       = SAMPLE_BITS + 5;
  localparam int PREP_STEPS  = 16;
  localparam int STEP_W      = $clog2(PREP_STEPS + 1);
  localparam int TIX_W       = $clog2(CODE_MAX);
  localparam int DVD_W       = SAMPLE_BITS + 8;
  localparam int RECIP_W     = DVD_W + 1;
  localparam int RECIP_SHIFT = DVD_W + 4;
  localparam int PROD_W      = DVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] SCALE_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(CODE_MAX) + 64'd1);

  typedef struct packed {
    logic init;
    logic flat;
    logic vld;
  } q4gq_ctl_t;

endpackage

FILE: hdl/q4gq_code.sv
// Threshold table and per-lane code compare for the 4-bit group quantizer.
module q4gq_code
  import q4gq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  q4gq_ctl_t              ctl_i,
  input  logic [SAMPLE_BITS-1:0] span_i,
  input  logic [SAMPLE_BITS-1:0] off_i,
  output logic [CODE_BITS-1:0]   code_o,
  output logic                   code_vld_o
);

  logic [NUM_W-1:0]     thr_q [CODE_MAX];
  logic [NUM_W-1:0]     acc_q;
  logic [TIX_W-1:0]     tix_q;
  logic                 tbusy_q;
  logic [NUM_W-1:0]     num_q;
  logic                 nvld_q;
  logic [CODE_BITS-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int k = 0; k < CODE_MAX; k++) begin
      if ((num_q > thr_q[k]) || ((num_q == thr_q[k]) && ((k & 1) == 1))) begin
        cnt = cnt + CODE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbusy_q && !ctl_i.init) begin
      thr_q[tix_q] <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbusy_q    <= 1'b0;
      tix_q      <= '0;
      acc_q      <= '0;
      nvld_q     <= 1'b0;
      num_q      <= '0;
      code_vld_o <= 1'b0;
      code_o     <= '0;
    end else begin
      if (ctl_i.init) begin
        acc_q   <= NUM_W'(span_i);
        tix_q   <= '0;
        tbusy_q <= 1'b1;
      end else if (tbusy_q) begin
        acc_q <= acc_q + NUM_W'({span_i, 1'b0});
        tix_q <= tix_q + TIX_W'(1);
        if (tix_q == TIX_W'(CODE_MAX - 1)) begin
          tbusy_q <= 1'b0;
        end
      end
      num_q      <= NUM_W'({off_i, 5'b0}) - NUM_W'({off_i, 1'b0});
      nvld_q     <= ctl_i.vld;
      code_o     <= ctl_i.flat ? '0 : cnt;
      code_vld_o <= nvld_q;
    end
  end

endmodule

FILE: hdl/q4_group_quantizer.sv
// Top level of the 4-bit min/max group quantizer: sample store, control and packing.
// Fill: one sample per cycle while busy_o is low; the 256th sample raises busy_o.
// Then the prep state takes the span, the scale (reciprocal multiply) and the code thresholds;
// then one store read per cycle, and valid_o once per packed word of 16 codes.
// busy_o stays high until the last packed word of the group is sent.
// The receiver cannot stall; reset clears control, count, minimum and maximum.
module q4_group_quantizer
  import q4gq_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          valid_o,
  output logic [WORD_BITS-1:0]          packed_word_o,
  output logic [WIDX_W-1:0]             word_index_o,
  output logic [SCALE_W-1:0]            group_scale_o,
  output logic signed [SAMPLE_BITS-1:0] group_minimum_o,
  output logic                          last_o
);

  typedef enum logic [1:0] {ST_FILL, ST_PREP, ST_QUANT} state_e;

  state_e                        state_q;
  logic [SAMPLE_BITS-1:0]        sample_mem [GROUP_SIZE];
  logic [SAMPLE_BITS-1:0]        rdata_q;
  logic [ADDR_W-1:0]             fill_q;
  logic signed [SAMPLE_BITS-1:0] min_q;
  logic signed [SAMPLE_BITS-1:0] max_q;
  logic [SAMPLE_BITS-1:0]        span_q;
  logic [STEP_W-1:0]             step_q;
  logic [SCALE_W-1:0]            scale_q;
  logic [PROD_W-1:0]             scale_prod;
  logic                          init_q;
  logic [ADDR_W:0]               rd_q;
  logic                          rd_vld_q;
  logic [SAMPLE_BITS-1:0]        off_q;
  logic                          off_vld_q;
  logic [ADDR_W-1:0]             out_cnt_q;
  logic [WORD_BITS-1:0]          word_q;
  logic [WORD_BITS-1:0]          word_d;
  logic                          wr_en;
  q4gq_ctl_t                     ctl;
  logic [CODE_BITS-1:0]          code;
  logic                          code_vld;

  assign busy_o          = (state_q != ST_FILL);
  assign wr_en           = start_i && (state_q == ST_FILL);
  assign scale_prod      = PROD_W'({span_q, 8'd7}) * PROD_W'(SCALE_RECIP);
  assign group_scale_o   = scale_q;
  assign group_minimum_o = min_q;
  assign word_d          = {code, word_q[WORD_BITS-1:CODE_BITS]};

  assign ctl.init = init_q;
  assign ctl.flat = (span_q == '0);
  assign ctl.vld  = off_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem[fill_q] <= sample_i;
    end
    rdata_q <= sample_mem[rd_q[ADDR_W-1:0]];
  end

  q4gq_code u_code (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .span_i     (span_q),
    .off_i      (off_q),
    .code_o     (code),
    .code_vld_o (code_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_FILL;
      fill_q        <= '0;
      min_q         <= '0;
      max_q         <= '0;
      span_q        <= '0;
      step_q        <= '0;
      scale_q       <= '0;
      init_q        <= 1'b0;
      rd_q          <= '0;
      rd_vld_q      <= 1'b0;
      off_q         <= '0;
      off_vld_q     <= 1'b0;
      out_cnt_q     <= '0;
      word_q        <= '0;
      valid_o       <= 1'b0;
      packed_word_o <= '0;
      word_index_o  <= '0;
      last_o        <= 1'b0;
    end else begin
      valid_o   <= 1'b0;
      init_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      off_vld_q <= rd_vld_q;
      off_q     <= rdata_q - SAMPLE_BITS'(min_q);
      unique case (state_q)
        ST_FILL: begin
          if (start_i) begin
            if (fill_q == '0) begin
              min_q <= sample_i;
              max_q <= sample_i;
            end else begin
              if (sample_i < min_q) min_q <= sample_i;
              if (sample_i > max_q) max_q <= sample_i;
            end
            fill_q <= fill_q + ADDR_W'(1);
            if (fill_q == ADDR_W'(GROUP_SIZE - 1)) begin
              state_q <= ST_PREP;
              step_q  <= '0;
            end
          end
        end
        ST_PREP: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == '0) begin
            span_q <= SAMPLE_BITS'(max_q) - SAMPLE_BITS'(min_q);
            init_q <= 1'b1;
          end
          if (step_q == STEP_W'(1)) begin
            scale_q <= scale_prod[RECIP_SHIFT +: SCALE_W];
          end
          if (step_q == STEP_W'(PREP_STEPS)) begin
            state_q   <= ST_QUANT;
            rd_q      <= '0;
            out_cnt_q <= '0;
          end
        end
        ST_QUANT: begin
          if (!rd_q[ADDR_W]) begin
            rd_vld_q <= 1'b1;
            rd_q     <= rd_q + (ADDR_W + 1)'(1);
          end
          if (code_vld) begin
            word_q    <= word_d;
            out_cnt_q <= out_cnt_q + ADDR_W'(1);
            if (out_cnt_q[LANE_W-1:0] == LANE_W'(LANES - 1)) begin
              valid_o       <= 1'b1;
              packed_word_o <= word_d;
              word_index_o  <= WIDX_W'(out_cnt_q[ADDR_W-1:LANE_W]);
              last_o        <= (out_cnt_q == ADDR_W'(GROUP_SIZE - 1));
              if (out_cnt_q == ADDR_W'(GROUP_SIZE - 1)) begin
                state_q <= ST_FILL;
              end
            end
          end
        end
        default: begin
          state_q <= ST_FILL;
        end
      endcase
    end
  end

endmodule

FILE: dv/q4_group_quantizer_checker.sv
`timescale 1ns / 100ps
// Checker for the 4-bit group quantizer: tracks accepted samples, predicts packed words, compares.
module q4_group_quantizer_checker
  import q4gq_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          valid_i,
  input  logic [WORD_BITS-1:0]          packed_word_i,
  input  logic [WIDX_W-1:0]             word_index_i,
  input  logic [SCALE_W-1:0]            group_scale_i,
  input  logic signed [SAMPLE_BITS-1:0] group_minimum_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            words_checked_o
);

  typedef struct {
    logic [WORD_BITS-1:0]          word;
    logic [WIDX_W-1:0]             index;
    logic [SCALE_W-1:0]            scale;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic                          last;
  } packed_result_t;

  logic signed [SAMPLE_BITS-1:0] group_store [GROUP_SIZE];
  logic signed [SAMPLE_BITS-1:0] group_lo;
  logic signed [SAMPLE_BITS-1:0] group_hi;
  int                            fill_count;
  packed_result_t                expected_words [$];
  int                            mismatches;
  int                            words_checked;
  int                            outstanding;

  assign fail_count_o    = mismatches;
  assign pending_o       = outstanding;
  assign words_checked_o = words_checked;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic logic [CODE_BITS-1:0] code_of(input int offset, input int span);
    int num;
    int q;
    int rem;
    if (span == 0) begin
      return '0;
    end
    num = offset * CODE_MAX;
    q   = num / span;
    rem = num % span;
    if (2 * rem > span || (2 * rem == span && (q % 2) == 1)) begin
      q++;
    end
    if (q > CODE_MAX) begin
      q = CODE_MAX;
    end
    return q[CODE_BITS-1:0];
  endfunction

  task automatic quantize_group();
    int             span;
    int             scale;
    packed_result_t res;
    span  = int'(group_hi) - int'(group_lo);
    scale = (span * 256 + 7) / CODE_MAX;
    for (int w = 0; w < WORD_COUNT; w++) begin
      res.word = '0;
      for (int j = 0; j < LANES; j++) begin
        res.word[CODE_BITS*j +: CODE_BITS] =
          code_of(int'(group_store[w*LANES+j]) - int'(group_lo), span);
      end
      res.index   = w[WIDX_W-1:0];
      res.scale   = scale[SCALE_W-1:0];
      res.minimum = group_lo;
      res.last    = (w == WORD_COUNT - 1);
      expected_words.push_back(res);
    end
  endtask

  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] v);
    if (fill_count == 0) begin
      group_lo = v;
      group_hi = v;
    end else begin
      if (v < group_lo) group_lo = v;
      if (v > group_hi) group_hi = v;
    end
    group_store[fill_count] = v;
    fill_count++;
    if (fill_count == GROUP_SIZE) begin
      fill_count = 0;
      quantize_group();
    end
  endtask

  task automatic check_word();
    packed_result_t exp;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word %0d with no request pending", word_index_i));
      return;
    end
    exp = expected_words.pop_front();
    words_checked++;
    if (packed_word_i !== exp.word)
      report_mismatch($sformatf("word %0d codes %h, want %h", exp.index, packed_word_i,
                                exp.word));
    if (word_index_i !== exp.index)
      report_mismatch($sformatf("word index %0d, want %0d", word_index_i, exp.index));
    if (group_scale_i !== exp.scale)
      report_mismatch($sformatf("word %0d scale %0d, want %0d", exp.index, group_scale_i,
                                exp.scale));
    if (group_minimum_i !== exp.minimum)
      report_mismatch($sformatf("word %0d minimum %0d, want %0d", exp.index,
                                group_minimum_i, exp.minimum));
    if (last_i !== exp.last)
      report_mismatch($sformatf("word %0d last %b, want %b", exp.index, last_i, exp.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count = 0;
      group_lo   = '0;
      group_hi   = '0;
      expected_words.delete();
      outstanding <= 0;
    end else begin
      if (valid_i) check_word();
      if (start_i && !busy_i) absorb_sample(sample_i);
      outstanding <= expected_words.size();
    end
  end

  initial begin
    mismatches    = 0;
    words_checked = 0;
  end

endmodule

FILE: dv/q4_group_quantizer_test.sv
`timescale 1ns / 100ps
// Testbench top for the 4-bit group quantizer: clock, reset, sample stimulus and verdict.
module q4_group_quantizer_test;
  import q4gq_pkg::*;

  localparam int LIMIT  = 250000;
  localparam int SETTLE = 300;

  logic                          clk_i   = 1'b0;
  logic                          rst_ni  = 1'b0;
  logic                          start_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          busy_o;
  logic                          valid_o;
  logic [WORD_BITS-1:0]          packed_word_o;
  logic [WIDX_W-1:0]             word_index_o;
  logic [SCALE_W-1:0]            group_scale_o;
  logic signed [SAMPLE_BITS-1:0] group_minimum_o;
  logic                          last_o;

  int fail_count;
  int pending;
  int words_checked;
  int cycles = 0;
  int groups_sent = 0;
  bit steady;

  logic signed [SAMPLE_BITS-1:0] lane_values [GROUP_SIZE];

  q4_group_quantizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .sample_i        (sample_i),
    .valid_o         (valid_o),
    .packed_word_o   (packed_word_o),
    .word_index_o    (word_index_o),
    .group_scale_o   (group_scale_o),
    .group_minimum_o (group_minimum_o),
    .last_o          (last_o)
  );

  q4_group_quantizer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .sample_i        (sample_i),
    .valid_i         (valid_o),
    .packed_word_i   (packed_word_o),
    .word_index_i    (word_index_o),
    .group_scale_i   (group_scale_o),
    .group_minimum_i (group_minimum_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("q4_group_quantizer_test NOT OK");
      $finish;
    end
  end

  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    sample_i <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic push_group();
    steady = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < GROUP_SIZE; i++) begin
      push_sample(lane_values[i]);
    end
    groups_sent++;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flat positive group: minimum must come from the first sample, not reset
    for (int i = 0; i < GROUP_SIZE; i++) lane_values[i] = 16'sd12345;
    push_group();
    // span of 65520 from the extremes: odd multiples of 2184 land exactly on a half step
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (i == 0) lane_values[i] = 16'sd32752;
      else if (i <= 30) lane_values[i] = SAMPLE_BITS'(-32768 + (i - 1) * 2184);
      else lane_values[i] = SAMPLE_BITS'(int'($urandom_range(0, 65520)) - 32768);
    end
    push_group();
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("ran %0d groups (%0d samples), %0d packed words compared", groups_sent,
             groups_sent * GROUP_SIZE, words_checked);
    $display("a flat group, then a nearly full-range group with exact half steps");
    if (fail_count == 0) begin
      $display("q4_group_quantizer_test OK");
    end else begin
      $display("q4_group_quantizer_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: q4_group_quantizer.f
hdl/q4gq_pkg.sv
hdl/q4gq_code.sv
hdl/q4_group_quantizer.sv
dv/q4_group_quantizer_checker.sv
dv/q4_group_quantizer_test.sv
